FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared types and codes for the sorted priority queue controller, datapath,
// channel interfaces and checker.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int ID_W    = 8;
   localparam int KEY_W   = 16;
   localparam int COUNT_W = 7;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_SCAN,
      ST_INS_PLACE,
      ST_DEL_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_LOAD_TOP,
      IDX_LOAD_ZERO,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      WR_AT_UP,
      WR_AT_DOWN,
      WR_AT_ZERO
   } wr_sel_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      idx_op_type idx_op;
      logic       wr_en;
      wr_sel_type wr_sel;
      logic       wr_new;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       set_status;
      status_type status_code;
      logic       set_found;
      logic       load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_delete;
      logic full;
      logic empty;
      logic key_gt;
      logic id_match;
      logic idx_zero;
      logic last;
      logic found;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: rtl/spq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid/ready channel carrying one insert or delete command.
// ----------------------------------------------------------------------------
interface spq_req_if;
   import spq_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [ID_W-1:0]   entry_id;
   logic [KEY_W-1:0]  entry_key;

   modport source (output valid, output command, output entry_id, output entry_key,
                   input ready);
   modport sink   (input valid, input command, input entry_id, input entry_key,
                   output ready);
endinterface

FILE: rtl/spq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue response channel
// Valid/ready channel carrying the status, count and head of the queue.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
   import spq_pkg::*;

   logic                valid;
   logic                ready;
   status_type          status;
   logic [COUNT_W-1:0]  entry_count;
   logic                head_valid;
   logic [ID_W-1:0]     head_id;
   logic [KEY_W-1:0]    head_key;

   modport source (output valid, output status, output entry_count, output head_valid,
                   output head_id, output head_key, input ready);
   modport sink   (input valid, input status, input entry_count, input head_valid,
                   input head_id, input head_key, output ready);
endinterface

FILE: rtl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Slot memory, scan index, fill count, head copy and the response register.
// ----------------------------------------------------------------------------
module spq_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_command,
   input  logic [spq_pkg::ID_W-1:0]    req_entry_id,
   input  logic [spq_pkg::KEY_W-1:0]   req_entry_key,
   input  spq_pkg::dp_cmd_type         cmd,
   output spq_pkg::dp_stat_type        stat,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output spq_pkg::status_type         rsp_status,
   output logic [spq_pkg::COUNT_W-1:0] rsp_entry_count,
   output logic                        rsp_head_valid,
   output logic [spq_pkg::ID_W-1:0]    rsp_head_id,
   output logic [spq_pkg::KEY_W-1:0]   rsp_head_key
);
   import spq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type             slot_mem [DEPTH];
   entry_type             rd_data_ff;
   entry_type             item_ff, item_in;
   logic                  is_delete_ff, is_delete_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         count_ff, count_in;
   entry_type             head_ff, head_in;
   logic                  found_ff, found_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_head_valid_ff, rsp_head_valid_in;
   entry_type             rsp_head_ff, rsp_head_in;

   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   entry_type             wr_data;
   logic [CW+COUNT_W-1:0] count_wide;

   // Read address follows the index update so the registered read data
   // always belongs to the current index.
   always_comb begin
      case (cmd.idx_op)
         IDX_LOAD_TOP:  idx_in = AW'(count_ff - CW'(1));
         IDX_LOAD_ZERO: idx_in = '0;
         IDX_DEC:       idx_in = idx_ff - AW'(1);
         IDX_INC:       idx_in = idx_ff + AW'(1);
         default:       idx_in = idx_ff;
      endcase
      rd_addr = idx_in;
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_AT_UP:   wr_addr = idx_ff + AW'(1);
         WR_AT_DOWN: wr_addr = idx_ff - AW'(1);
         default:    wr_addr = '0;
      endcase
      wr_data = cmd.wr_new ? item_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_comb begin
      item_in      = cmd.capture ? entry_type'{id: req_entry_id, key: req_entry_key}
                                 : item_ff;
      is_delete_in = cmd.capture ? req_command : is_delete_ff;
      head_in      = (cmd.wr_en && wr_addr == '0) ? wr_data : head_ff;
      found_in     = cmd.capture ? 1'b0 : (found_ff | cmd.set_found);
      status_in    = cmd.set_status ? cmd.status_code : status_ff;

      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end

      // The reported count is the fill count reduced to the field width.
      count_wide        = {{COUNT_W{1'b0}}, count_ff};
      rsp_count_in      = cmd.load_out ? count_wide[COUNT_W-1:0] : rsp_count_ff;
      rsp_status_in     = cmd.load_out ? status_ff : rsp_status_ff;
      rsp_head_valid_in = cmd.load_out ? (count_ff != '0) : rsp_head_valid_ff;
      rsp_head_in       = rsp_head_ff;
      if (cmd.load_out) begin
         rsp_head_in = (count_ff != '0) ? head_ff : '0;
      end

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff           <= item_in;
      is_delete_ff      <= is_delete_in;
      idx_ff            <= idx_in;
      head_ff           <= head_in;
      found_ff          <= found_in;
      status_ff         <= status_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_head_valid_ff <= rsp_head_valid_in;
      rsp_head_ff       <= rsp_head_in;
   end

   always_comb begin
      stat.is_delete = is_delete_ff;
      stat.full      = (count_ff == CW'(DEPTH));
      stat.empty     = (count_ff == '0);
      stat.key_gt    = (rd_data_ff.key > item_ff.key);
      stat.id_match  = (rd_data_ff.id == item_ff.id);
      stat.idx_zero  = (idx_ff == '0);
      stat.last      = (CW'(idx_ff) == count_ff - CW'(1));
      stat.found     = found_ff;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_head_valid  = rsp_head_valid_ff;
   assign rsp_head_id     = rsp_head_ff.id;
   assign rsp_head_key    = rsp_head_ff.key;

endmodule

FILE: rtl/spq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences the insert scan-and-shift and the delete search-and-close passes.
// ----------------------------------------------------------------------------
module spq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::dp_stat_type  stat,
   output spq_pkg::dp_cmd_type   cmd
);
   import spq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (stat.is_delete) begin
               state_in = stat.empty ? ST_FINISH : ST_DEL_SCAN;
            end else if (stat.full || stat.empty) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_INS_SCAN;
            end
         end
         ST_INS_SCAN: begin
            if (!stat.key_gt) begin
               state_in = ST_FINISH;
            end else if (stat.idx_zero) begin
               state_in = ST_INS_PLACE;
            end
         end
         ST_INS_PLACE: state_in = ST_FINISH;
         ST_DEL_SCAN: begin
            if (stat.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.idx_op      = IDX_HOLD;
      cmd.wr_sel      = WR_AT_UP;
      cmd.status_code = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DISPATCH: begin
            cmd.set_status = 1'b1;
            if (stat.is_delete) begin
               if (stat.empty) begin
                  cmd.status_code = STATUS_EMPTY;
               end else begin
                  cmd.idx_op = IDX_LOAD_ZERO;
               end
            end else if (stat.full) begin
               cmd.status_code = STATUS_OVERFLOW;
            end else if (stat.empty) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_AT_ZERO;
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
            end else begin
               cmd.idx_op = IDX_LOAD_TOP;
            end
         end
         ST_INS_SCAN: begin
            // Walk down from the top, moving larger keys up one slot until
            // the new entry's place is found.
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_AT_UP;
            if (stat.key_gt) begin
               if (!stat.idx_zero) begin
                  cmd.idx_op = IDX_DEC;
               end
            end else begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_INS_PLACE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_AT_ZERO;
            cmd.wr_new  = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         ST_DEL_SCAN: begin
            // Once the first match is seen, every later entry moves down one.
            if (stat.found) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_AT_DOWN;
            end else if (stat.id_match) begin
               cmd.set_found = 1'b1;
            end
            if (stat.last) begin
               cmd.set_status = 1'b1;
               if (stat.found || stat.id_match) begin
                  cmd.cnt_dec = 1'b1;
               end else begin
                  cmd.status_code = STATUS_NOT_FOUND;
               end
            end else begin
               cmd.idx_op = IDX_INC;
            end
         end
         ST_FINISH: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            cmd.idx_op = IDX_HOLD;
         end
      endcase
   end

endmodule

FILE: rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// From request transfer to response valid, an insert goes straight to the response
// when the queue is full or empty, and otherwise shifts each larger entry up one slot.
// A delete scans every entry, or goes straight to the response on an empty queue.
// Throughput: one command at a time; the next request can transfer as soon as the
// result is registered, and a stalled response holds the controller in place.
// Reset clears the count and the response valid; the slot memory is not cleared.
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Priority queue of entries held in a memory sorted by key, with insert by
// key and delete by id, reporting status, count and head on every command.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
   parameter int DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   spq_req_if.sink      req_if,
   spq_rsp_if.source    rsp_if
);
   import spq_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   spq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_if.command),
      .req_entry_id    (req_if.entry_id),
      .req_entry_key   (req_if.entry_key),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_status      (rsp_if.status),
      .rsp_entry_count (rsp_if.entry_count),
      .rsp_head_valid  (rsp_if.head_valid),
      .rsp_head_id     (rsp_if.head_id),
      .rsp_head_key    (rsp_if.head_key)
   );

endmodule

FILE: rtl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on the response channel of the queue unit.
// ----------------------------------------------------------------------------
module spq_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  spq_pkg::status_type         rsp_status,
   input  logic [spq_pkg::COUNT_W-1:0] rsp_entry_count,
   input  logic                        rsp_head_valid,
   input  logic [spq_pkg::ID_W-1:0]    rsp_head_id,
   input  logic [spq_pkg::KEY_W-1:0]   rsp_head_key
);
   import spq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count) && $stable(rsp_head_id) && $stable(rsp_head_key))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> rsp_entry_count == '0
         && rsp_head_id == '0 && rsp_head_key == '0)
      else $error("empty queue reports a head entry");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> !rsp_head_valid)
      else $error("empty status with a head entry");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status      (rsp_if.status),
   .rsp_entry_count (rsp_if.entry_count),
   .rsp_head_valid  (rsp_if.head_valid),
   .rsp_head_id     (rsp_if.head_id),
   .rsp_head_key    (rsp_if.head_key)
);
